// ----- rtl/core/ray_triangle_closest_hit_macros.svh -----
// Assertion helpers for the nearest-hit search block.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_MACROS_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RTCH_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RTCH_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/rtch_pkg.sv -----
package rtch_pkg;

  // Fixed formats of the datapath.
  localparam int INDEX_WIDTH = 20;
  localparam int FRAC_BITS   = 16;

  typedef struct packed {
    logic signed [31:0] vertex0_x;
    logic signed [31:0] vertex0_y;
    logic signed [31:0] vertex0_z;
    logic signed [31:0] vertex1_x;
    logic signed [31:0] vertex1_y;
    logic signed [31:0] vertex1_z;
    logic signed [31:0] vertex2_x;
    logic signed [31:0] vertex2_y;
    logic signed [31:0] vertex2_z;
    logic [19:0]        tri_index;
    logic               last_tri;
  } tri_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] hit_distance;
    logic [16:0] bary_u;
    logic [16:0] bary_v;
    logic [19:0] hit_index;
  } result_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_EPSILON  = 3'd6;

  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;
  localparam logic [16:0] BARY_MAX = 17'h1_FFFF;

  // Ray setup held at the top level and used by the front part.
  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
    logic [15:0]        eps;
  } ray_t;

endpackage

// ----- rtl/core/ray_triangle_closest_hit.sv -----
// Nearest ray/triangle hit search. Load the ray and tolerance through the
// configuration port, then stream triangles; the triangle marked last
// produces one result and clears the search. The front works on one
// triangle at a time: an accept step, 12 cross-product steps, 24
// dot-product steps (two per term on one shared 34 by 33 bit multiplier)
// and a handoff step. A triangle that passes the test then holds the back
// for a take step, three divisions for distance, u and v at one quotient
// bit a cycle, and a finish step; a miss goes from the take step straight
// to the finish step. A one-entry handoff between the two lets the front
// work on the next triangle while the back divides, so during a run of
// hits the divisions pace the input, more slowly while a result is stalled.
module ray_triangle_closest_hit import rtch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  tri_t        in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_data
);

  ray_t ray;
  logic q_valid, q_cand, q_last, q_full;
  logic [19:0] q_index;
  logic [127:0] q_a, q_nu, q_nv, q_nt;

  assign cfg_ready = 1'b1;

  // Register file for the ray.
  always_ff @(posedge clk) begin
    if (rst) begin
      ray <= '{ox: '0, oy: '0, oz: '0, dx: '0, dy: '0, dz: 32'sd65536, eps: 16'd1};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X: ray.ox <= cfg_data;
        REG_ORIGIN_Y: ray.oy <= cfg_data;
        REG_ORIGIN_Z: ray.oz <= cfg_data;
        REG_DIR_X:    ray.dx <= cfg_data;
        REG_DIR_Y:    ray.dy <= cfg_data;
        REG_DIR_Z:    ray.dz <= cfg_data;
        REG_EPSILON:  ray.eps <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rtch_front u_front (
    .clk, .rst, .ray, .tri_in(in_data), .tri_valid(in_valid), .tri_stall(in_stall),
    .q_valid, .q_cand, .q_last, .q_index, .q_a, .q_nu, .q_nv, .q_nt, .q_full
  );

  rtch_back u_back (
    .clk, .rst, .q_valid(q_valid && !q_full), .q_cand, .q_last, .q_index,
    .q_a, .q_nu, .q_nv, .q_nt, .q_full,
    .res_valid(out_valid), .res(out_data), .res_stall(out_stall)
  );

endmodule

// ----- rtl/core/rtch_front.sv -----
// Front part: accepts a triangle, forms edge and offset vectors and
// evaluates the four determinant-scaled terms with one shared multiplier,
// then classifies the triangle as a candidate or a miss.
module rtch_front import rtch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ray_t        ray,
  input  tri_t        tri_in,
  input  logic        tri_valid,
  output logic        tri_stall,
  output logic        q_valid,
  output logic        q_cand,
  output logic        q_last,
  output logic [19:0] q_index,
  output logic [127:0] q_a,
  output logic [127:0] q_nu,
  output logic [127:0] q_nv,
  output logic [127:0] q_nt,
  input  logic        q_full
);

  localparam logic [4:0] ST_IDLE = 5'd0;

  // Step codes of the multiply sequence.
  localparam logic [4:0] S_H0A = 5'd1,  S_H0B = 5'd2,  S_H1A = 5'd3,  S_H1B = 5'd4;
  localparam logic [4:0] S_H2A = 5'd5,  S_H2B = 5'd6,  S_Q0A = 5'd7,  S_Q0B = 5'd8;
  localparam logic [4:0] S_Q1A = 5'd9,  S_Q1B = 5'd10, S_Q2A = 5'd11, S_Q2B = 5'd12;
  localparam logic [4:0] S_A0  = 5'd13, S_A1  = 5'd14, S_A2  = 5'd15;
  localparam logic [4:0] S_U0  = 5'd16, S_U1  = 5'd17, S_U2  = 5'd18;
  localparam logic [4:0] S_V0  = 5'd19, S_V1  = 5'd20, S_V2  = 5'd21;
  localparam logic [4:0] S_T0  = 5'd22, S_T1  = 5'd23, S_T2  = 5'd24;
  localparam logic [4:0] S_CLS = 5'd25;

  logic [4:0] state;
  logic signed [32:0] e1 [3];
  logic signed [32:0] e2 [3];
  logic signed [32:0] s  [3];
  logic signed [65:0] h  [3];
  logic signed [65:0] q  [3];
  logic signed [99:0] a, nu, nv, nt;
  logic [19:0] idx;
  logic last;
  logic half;
  logic dot_step;
  logic signed [65:0] mul_x;
  logic signed [32:0] mul_y;
  logic signed [33:0] mul_a;
  logic signed [66:0] mul_r;
  logic signed [65:0] mul_p;
  logic signed [99:0] mul_w;
  logic signed [99:0] a_abs, nu_f, nv_f, nt_f;
  logic cand;

  assign tri_stall = (state != ST_IDLE);

  // One shared 34 by 33 bit multiplier. Cross products take one step per
  // term; a dot product term takes the 66-bit cross term in a low and a
  // high half over two steps.
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state)
      S_H0A: begin mul_x = 66'(ray.dy); mul_y = e2[2]; end
      S_H0B: begin mul_x = 66'(ray.dz); mul_y = e2[1]; end
      S_H1A: begin mul_x = 66'(ray.dz); mul_y = e2[0]; end
      S_H1B: begin mul_x = 66'(ray.dx); mul_y = e2[2]; end
      S_H2A: begin mul_x = 66'(ray.dx); mul_y = e2[1]; end
      S_H2B: begin mul_x = 66'(ray.dy); mul_y = e2[0]; end
      S_Q0A: begin mul_x = 66'(s[1]); mul_y = e1[2]; end
      S_Q0B: begin mul_x = 66'(s[2]); mul_y = e1[1]; end
      S_Q1A: begin mul_x = 66'(s[2]); mul_y = e1[0]; end
      S_Q1B: begin mul_x = 66'(s[0]); mul_y = e1[2]; end
      S_Q2A: begin mul_x = 66'(s[0]); mul_y = e1[1]; end
      S_Q2B: begin mul_x = 66'(s[1]); mul_y = e1[0]; end
      S_A0:  begin mul_x = h[0]; mul_y = e1[0]; end
      S_A1:  begin mul_x = h[1]; mul_y = e1[1]; end
      S_A2:  begin mul_x = h[2]; mul_y = e1[2]; end
      S_U0:  begin mul_x = h[0]; mul_y = s[0]; end
      S_U1:  begin mul_x = h[1]; mul_y = s[1]; end
      S_U2:  begin mul_x = h[2]; mul_y = s[2]; end
      S_V0:  begin mul_x = q[0]; mul_y = 33'(ray.dx); end
      S_V1:  begin mul_x = q[1]; mul_y = 33'(ray.dy); end
      S_V2:  begin mul_x = q[2]; mul_y = 33'(ray.dz); end
      S_T0:  begin mul_x = q[0]; mul_y = e2[0]; end
      S_T1:  begin mul_x = q[1]; mul_y = e2[1]; end
      S_T2:  begin mul_x = q[2]; mul_y = e2[2]; end
      default: ;
    endcase
    dot_step = (state >= S_A0) && (state <= S_T2);
    if (dot_step) begin
      mul_a = half ? {mul_x[65], mul_x[65:33]} : {1'b0, mul_x[32:0]};
    end else begin
      mul_a = mul_x[33:0];
    end
    mul_r = 67'(mul_a * mul_y);
    mul_p = mul_r[65:0];
    mul_w = half ? (100'(mul_r) <<< 33) : 100'(mul_r);
  end

  // Sign normalization and acceptance test.
  always_comb begin
    logic signed [101:0] sum_uv;
    logic signed [117:0] lhs, rhs;
    a_abs = a[99] ? -a : a;
    nu_f  = a[99] ? -nu : nu;
    nv_f  = a[99] ? -nv : nv;
    nt_f  = a[99] ? -nt : nt;
    sum_uv = 102'(nu_f) + 102'(nv_f);
    lhs = 118'(nt_f) <<< FRAC_BITS;
    rhs = 118'($signed({1'b0, ray.eps})) * 118'(a_abs);
    cand = (a_abs != '0)
        && (a_abs >= (100'(ray.eps) << (2 * FRAC_BITS)))
        && !nu_f[99] && !nv_f[99]
        && (sum_uv <= 102'(a_abs))
        && (rhs < lhs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      q_valid <= 1'b0;
      half <= 1'b0;
    end else begin
      // Handoff register: loaded when the classified triangle finds room.
      if (state == S_CLS && (!q_valid || !q_full)) q_valid <= 1'b1;
      else if (q_valid && !q_full) q_valid <= 1'b0;
      case (state)
        ST_IDLE: if (tri_valid) begin
          e1[0] <= 33'(tri_in.vertex1_x) - 33'(tri_in.vertex0_x);
          e1[1] <= 33'(tri_in.vertex1_y) - 33'(tri_in.vertex0_y);
          e1[2] <= 33'(tri_in.vertex1_z) - 33'(tri_in.vertex0_z);
          e2[0] <= 33'(tri_in.vertex2_x) - 33'(tri_in.vertex0_x);
          e2[1] <= 33'(tri_in.vertex2_y) - 33'(tri_in.vertex0_y);
          e2[2] <= 33'(tri_in.vertex2_z) - 33'(tri_in.vertex0_z);
          s[0]  <= 33'(ray.ox) - 33'(tri_in.vertex0_x);
          s[1]  <= 33'(ray.oy) - 33'(tri_in.vertex0_y);
          s[2]  <= 33'(ray.oz) - 33'(tri_in.vertex0_z);
          idx   <= tri_in.tri_index;
          last  <= tri_in.last_tri;
          half  <= 1'b0;
          state <= S_H0A;
        end
        S_H0A: begin h[0] <= mul_p; state <= S_H0B; end
        S_H0B: begin h[0] <= h[0] - mul_p; state <= S_H1A; end
        S_H1A: begin h[1] <= mul_p; state <= S_H1B; end
        S_H1B: begin h[1] <= h[1] - mul_p; state <= S_H2A; end
        S_H2A: begin h[2] <= mul_p; state <= S_H2B; end
        S_H2B: begin h[2] <= h[2] - mul_p; state <= S_Q0A; end
        S_Q0A: begin q[0] <= mul_p; state <= S_Q0B; end
        S_Q0B: begin q[0] <= q[0] - mul_p; state <= S_Q1A; end
        S_Q1A: begin q[1] <= mul_p; state <= S_Q1B; end
        S_Q1B: begin q[1] <= q[1] - mul_p; state <= S_Q2A; end
        S_Q2A: begin q[2] <= mul_p; state <= S_Q2B; end
        S_Q2B: begin q[2] <= q[2] - mul_p; state <= S_A0; end
        // Each dot step runs twice: low half, then high half.
        S_A0: begin a <= half ? a + mul_w : mul_w; half <= !half; if (half) state <= S_A1; end
        S_A1: begin a <= a + mul_w; half <= !half; if (half) state <= S_A2; end
        S_A2: begin a <= a + mul_w; half <= !half; if (half) state <= S_U0; end
        S_U0: begin nu <= half ? nu + mul_w : mul_w; half <= !half; if (half) state <= S_U1; end
        S_U1: begin nu <= nu + mul_w; half <= !half; if (half) state <= S_U2; end
        S_U2: begin nu <= nu + mul_w; half <= !half; if (half) state <= S_V0; end
        S_V0: begin nv <= half ? nv + mul_w : mul_w; half <= !half; if (half) state <= S_V1; end
        S_V1: begin nv <= nv + mul_w; half <= !half; if (half) state <= S_V2; end
        S_V2: begin nv <= nv + mul_w; half <= !half; if (half) state <= S_T0; end
        S_T0: begin nt <= half ? nt + mul_w : mul_w; half <= !half; if (half) state <= S_T1; end
        S_T1: begin nt <= nt + mul_w; half <= !half; if (half) state <= S_T2; end
        S_T2: begin nt <= nt + mul_w; half <= !half; if (half) state <= S_CLS; end
        S_CLS: begin
          // Hand the classified triangle to the queue once it has room.
          if (!q_valid || !q_full) begin
            q_cand  <= cand;
            q_last  <= last;
            q_index <= idx;
            q_a     <= 128'(a_abs);
            q_nu    <= 128'(nu_f);
            q_nv    <= 128'(nv_f);
            q_nt    <= 128'(nt_f);
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/rtch_back.sv -----
// Back part: divides the surviving candidate's terms by the determinant
// one quotient bit a cycle, keeps the nearest hit and emits the result on
// the last triangle through an output register.
module rtch_back import rtch_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  logic         q_cand,
  input  logic         q_last,
  input  logic [19:0]  q_index,
  input  logic [127:0] q_a,
  input  logic [127:0] q_nu,
  input  logic [127:0] q_nv,
  input  logic [127:0] q_nt,
  output logic         q_full,
  output logic         res_valid,
  output result_t      res,
  input  logic         res_stall
);

  localparam logic [2:0] B_IDLE = 3'd0, B_DT = 3'd1, B_DU = 3'd2, B_DV = 3'd3;
  localparam logic [2:0] B_FIN  = 3'd4;

  logic [2:0] state;
  logic [127:0] den, num, rem, quo, nu_s, nv_s;
  logic [6:0] cnt;
  logic cand, last;
  logic [19:0] idx;
  logic [30:0] best_distance, cand_dist;
  logic [16:0] best_u, best_v, u_val;
  logic [19:0] best_index;
  logic found, take;
  logic [127:0] rem_sh;
  logic div_bit;
  logic [127:0] div_rem;

  assign q_full = (state != B_IDLE);
  assign rem_sh = {rem[126:0], num[127]};
  assign div_bit = (rem_sh >= den);
  assign div_rem = div_bit ? rem_sh - den : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      res_valid <= 1'b0;
      found <= 1'b0;
      best_distance <= DIST_MAX;
      best_u <= '0; best_v <= '0; best_index <= '0;
    end else begin
      // Output register: loaded by the last triangle once it is free.
      if (state == B_FIN && last && (!res_valid || !res_stall)) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;
      case (state)
        B_IDLE: if (q_valid) begin
          cand <= q_cand; last <= q_last;
          idx  <= 20'(q_index & 20'((64'd1 << INDEX_WIDTH) - 64'd1));
          den  <= q_a;
          num  <= q_nt << FRAC_BITS;
          nu_s <= q_nu << FRAC_BITS;
          nv_s <= q_nv << FRAC_BITS;
          rem <= '0; quo <= '0; cnt <= '0;
          state <= q_cand ? B_DT : B_FIN;
        end
        B_DT, B_DU, B_DV: begin
          // Restoring division, one quotient bit a cycle.
          if (cnt == 7'd127) begin
            quo <= {quo[126:0], div_bit};
            rem <= '0; cnt <= '0;
            if (state == B_DT) begin
              num <= nu_s;
              state <= B_DU;
            end else if (state == B_DU) begin
              num <= nv_s;
              state <= B_DV;
            end else begin
              state <= B_FIN;
            end
          end else begin
            num <= num << 1;
            rem <= div_rem;
            cnt <= cnt + 7'd1;
            // The first bit of a pass starts a fresh quotient.
            if (cnt == 7'd0) quo <= {127'd0, div_bit};
            else quo <= {quo[126:0], div_bit};
          end
          // The previous pass's quotient is complete in its first cycle.
          if (cnt == 7'd0 && state == B_DU) begin
            cand_dist <= (quo[127:31] != '0) ? DIST_MAX : quo[30:0];
          end
          if (cnt == 7'd0 && state == B_DV) begin
            u_val <= (quo[127:17] != '0) ? BARY_MAX : quo[16:0];
          end
        end
        B_FIN: if (!res_valid || !res_stall) begin
          if (cand && take) begin
            best_distance <= cand_dist;
            best_u <= u_val;
            best_v <= (quo[127:17] != '0) ? BARY_MAX : quo[16:0];
            best_index <= idx;
            found <= 1'b1;
          end
          if (last) begin
            if (cand && take) begin
              res.hit <= 1'b1; res.hit_distance <= cand_dist; res.bary_u <= u_val;
              res.bary_v <= (quo[127:17] != '0) ? BARY_MAX : quo[16:0];
              res.hit_index <= idx;
            end else if (found) begin
              res.hit <= 1'b1; res.hit_distance <= best_distance;
              res.bary_u <= best_u; res.bary_v <= best_v;
              res.hit_index <= best_index;
            end else begin
              res <= '0;
            end
            found <= 1'b0;
            best_distance <= DIST_MAX;
            best_u <= '0; best_v <= '0; best_index <= '0;
          end
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Strict less-than keeps the earlier triangle on equal distances.
  assign take = !found || (cand_dist < best_distance);

endmodule

// ----- rtl/core/rtch_checker.sv -----
`include "ray_triangle_closest_hit_macros.svh"
// Port-level checks for the nearest-hit search block.
module rtch_checker import rtch_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_stall,
  input result_t out_data,
  input logic    in_valid,
  input logic    in_stall
);
  `RTCH_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `RTCH_ASSERT_IMP(a_miss_zero, out_valid && !out_data.hit, out_data.hit_distance == '0)
  `RTCH_ASSERT_IMP(a_u_range, out_valid, out_data.bary_u <= 17'd65536)
  `RTCH_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall)
endmodule

bind ray_triangle_closest_hit rtch_checker u_checker (
  .clk, .rst, .out_valid, .out_stall, .out_data, .in_valid, .in_stall
);

// ----- verif/tb_ray_triangle_closest_hit.sv -----
`timescale 1ns / 1ps

module tb_ray_triangle_closest_hit;
  import rtch_pkg::*;

  localparam int ONE = 65536;
  localparam int DRAIN_CYCLES = 1000;
  // An index past the register list; writes to it are ignored.
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef logic signed [127:0] wide_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tri_t        in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     out_data;

  ray_triangle_closest_hit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the ray registers and of the running nearest-hit search.
  logic signed [31:0] ray_ox = 0, ray_oy = 0, ray_oz = 0;
  logic signed [31:0] ray_dx = 0, ray_dy = 0, ray_dz = ONE;
  logic [15:0]        ray_eps = 16'd1;
  logic [30:0] near_dist = DIST_MAX;
  logic [16:0] near_u = '0, near_v = '0;
  logic [19:0] near_index = '0;
  logic        near_found = 1'b0;

  tri_t    pending_tris[$];
  result_t expected_hits[$];
  int      errors = 0;
  int      tri_count = 0;
  int      ray_count = 0;
  int      hit_count = 0;
  bit      calm = 1'b0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic wide_t widen(logic signed [31:0] x);
    wide_t r;
    r = x;
    return r;
  endfunction

  function automatic void cross3(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic wide_t dot3(input wide_t a[3], input wide_t b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // Exact Moller-Trumbore test on one triangle; updates the nearest hit and
  // queues the ray result when the triangle closes the ray.
  function automatic void score_triangle(tri_t t);
    wide_t p0[3], p1[3], p2[3], o[3], d[3], e1[3], e2[3], s[3], h[3], q[3];
    wide_t a, nu, nv, nt, ew, quo;
    logic [30:0] cand_dist;
    result_t r;
    p0[0] = widen(t.vertex0_x); p0[1] = widen(t.vertex0_y); p0[2] = widen(t.vertex0_z);
    p1[0] = widen(t.vertex1_x); p1[1] = widen(t.vertex1_y); p1[2] = widen(t.vertex1_z);
    p2[0] = widen(t.vertex2_x); p2[1] = widen(t.vertex2_y); p2[2] = widen(t.vertex2_z);
    o[0] = widen(ray_ox); o[1] = widen(ray_oy); o[2] = widen(ray_oz);
    d[0] = widen(ray_dx); d[1] = widen(ray_dy); d[2] = widen(ray_dz);
    for (int i = 0; i < 3; i++) begin
      e1[i] = p1[i] - p0[i];
      e2[i] = p2[i] - p0[i];
      s[i]  = o[i] - p0[i];
    end
    cross3(d, e2, h);
    a  = dot3(e1, h);
    nu = dot3(s, h);
    cross3(s, e1, q);
    nv = dot3(d, q);
    nt = dot3(e2, q);
    if (a < 0) begin
      a = -a; nu = -nu; nv = -nv; nt = -nt;
    end
    ew = {112'd0, ray_eps};
    if (a != 0 && a >= (ew <<< 32) && nu >= 0 && nv >= 0 && nu + nv <= a &&
        (nt <<< 16) > ew * a) begin
      quo = (nt <<< 16) / a;
      cand_dist = (quo > wide_t'(DIST_MAX)) ? DIST_MAX : quo[30:0];
      // Strict less-than keeps the earlier triangle on a tie.
      if (!near_found || cand_dist < near_dist) begin
        near_dist = cand_dist;
        quo = (nu <<< 16) / a;
        near_u = (quo > wide_t'(BARY_MAX)) ? BARY_MAX : quo[16:0];
        quo = (nv <<< 16) / a;
        near_v = (quo > wide_t'(BARY_MAX)) ? BARY_MAX : quo[16:0];
        near_index = t.tri_index;
        near_found = 1'b1;
      end
    end
    if (t.last_tri) begin
      r = '0;
      if (near_found) begin
        r.hit = 1'b1;
        r.hit_distance = near_dist;
        r.bary_u = near_u;
        r.bary_v = near_v;
        r.hit_index = near_index;
        hit_count++;
      end
      expected_hits.push_back(r);
      ray_count++;
      near_dist = DIST_MAX;
      near_u = '0;
      near_v = '0;
      near_index = '0;
      near_found = 1'b0;
    end
  endfunction

  // Request driver: presents queued triangles, holding a stalled request.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        score_triangle(in_data);
        tri_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_tris.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
          in_valid <= 1'b1;
          in_data <= pending_tris.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure and field-by-field compare.
  always @(posedge clk) begin
    result_t want;
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);
    if (!rst && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data.hit_index), 0);
      end else begin
        want = expected_hits.pop_front();
        if (out_data.hit !== want.hit)
          report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
        if (out_data.hit_distance !== want.hit_distance)
          report_mismatch("hit_distance", 32'(out_data.hit_distance),
                          32'(want.hit_distance));
        if (out_data.bary_u !== want.bary_u)
          report_mismatch("bary_u", 32'(out_data.bary_u), 32'(want.bary_u));
        if (out_data.bary_v !== want.bary_v)
          report_mismatch("bary_v", 32'(out_data.bary_v), 32'(want.bary_v));
        if (out_data.hit_index !== want.hit_index)
          report_mismatch("hit_index", 32'(out_data.hit_index), 32'(want.hit_index));
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ORIGIN_X: ray_ox = value;
      REG_ORIGIN_Y: ray_oy = value;
      REG_ORIGIN_Z: ray_oz = value;
      REG_DIR_X:    ray_dx = value;
      REG_DIR_Y:    ray_dy = value;
      REG_DIR_Z:    ray_dz = value;
      REG_EPSILON:  ray_eps = value[15:0];
      default: ;
    endcase
  endtask

  task automatic load_ray(int ox, int oy, int oz, int dx, int dy, int dz, int eps);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_EPSILON, eps);
  endtask

  function automatic tri_t make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                    int x2, int y2, int z2, int idx, bit last);
    tri_t t;
    t.vertex0_x = x0; t.vertex0_y = y0; t.vertex0_z = z0;
    t.vertex1_x = x1; t.vertex1_y = y1; t.vertex1_z = z1;
    t.vertex2_x = x2; t.vertex2_y = y2; t.vertex2_z = z2;
    t.tri_index = 20'(idx);
    t.last_tri = last;
    return t;
  endfunction

  // Unit triangle in the plane z, straddling the z axis.
  function automatic tri_t flat_tri(int z, int idx, bit last);
    return make_tri(-ONE, -ONE, z, ONE, -ONE, z, 0, ONE, z, idx, last);
  endfunction

  // Triangle placed around a point a few steps along the current ray.
  function automatic tri_t aimed_tri(bit last);
    int k, cx, cy, cz;
    k = $urandom_range(1, 8);
    cx = ray_ox + ray_dx * k;
    cy = ray_oy + ray_dy * k;
    cz = ray_oz + ray_dz * k;
    return make_tri(cx - $urandom_range(1, 2 * ONE), cy - $urandom_range(1, 2 * ONE),
                    cz + $urandom_range(0, ONE) - ONE / 2,
                    cx + $urandom_range(1, 2 * ONE), cy - $urandom_range(1, 2 * ONE),
                    cz + $urandom_range(0, ONE) - ONE / 2,
                    cx + $urandom_range(0, ONE) - ONE / 2, cy + $urandom_range(1, 2 * ONE),
                    cz + $urandom_range(0, ONE) - ONE / 2,
                    $urandom_range(0, 20'hFFFFF), last);
  endfunction

  function automatic tri_t noise_tri(bit last);
    return make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom_range(0, 20'hFFFFF), last);
  endfunction

  // Rays of one to eight triangles; mostly aimed, some pure noise.
  task automatic queue_random_rays(int n_tris);
    int left, len;
    left = n_tris;
    while (left > 0) begin
      len = $urandom_range(1, 8);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 75)
          pending_tris.push_back(aimed_tri(i == len - 1));
        else
          pending_tris.push_back(noise_tri(i == len - 1));
      end
      left -= len;
    end
  endtask

  // Wait until every request is taken and every result is back, then let
  // the back end finish any triangle that produces no result.
  task automatic drain;
    while (pending_tris.size() > 0 || in_valid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int small_coord();
    return $signed($urandom_range(0, 40 * ONE)) - 20 * ONE;
  endfunction

  function automatic int small_dir();
    return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
  endfunction

  initial begin
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset ray along +z: nearest of two, tie keeps first, miss, behind.
    pending_tris.push_back(flat_tri(5 * ONE, 11, 1'b0));
    pending_tris.push_back(flat_tri(3 * ONE, 12, 1'b1));
    pending_tris.push_back(flat_tri(4 * ONE, 20, 1'b0));
    pending_tris.push_back(flat_tri(4 * ONE, 21, 1'b1));
    pending_tris.push_back(make_tri(5 * ONE, 5 * ONE, ONE, 6 * ONE, 5 * ONE, ONE,
                                    5 * ONE, 6 * ONE, ONE, 30, 1'b1));
    pending_tris.push_back(flat_tri(-5 * ONE, 31, 1'b1));
    // Ray through a corner and along an edge.
    pending_tris.push_back(make_tri(0, 0, 2 * ONE, ONE, 0, 2 * ONE, 0, ONE, 2 * ONE,
                                    40, 1'b1));
    pending_tris.push_back(make_tri(-ONE, 0, 2 * ONE, ONE, 0, 2 * ONE, 0, ONE, 2 * ONE,
                                    41, 1'b1));
    // Field extremes.
    pending_tris.push_back(make_tri(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                    32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                    32'h80000000, 32'h80000000, 32'h7FFFFFFF, 20'hFFFFF, 1'b0));
    pending_tris.push_back(make_tri(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                    32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                    0, 32'h7FFFFFFF, 32'h7FFFFFFF, 20'h00000, 1'b1));
    pending_tris.push_back(flat_tri(ONE, 20'hFFFFF, 1'b1));
    queue_random_rays(250);
    drain();

    // Zero tolerance: degenerate and edge-on triangles still miss.
    write_reg(REG_EPSILON, 0);
    write_reg(REG_NONE, 32'hFFFFFFFF);
    pending_tris.push_back(make_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 50, 1'b1));
    pending_tris.push_back(make_tri(0, -ONE, ONE, 0, ONE, ONE, 0, 0, 3 * ONE, 51, 1'b1));
    pending_tris.push_back(flat_tri(ONE, 52, 1'b1));
    queue_random_rays(250);
    drain();

    // Tiny direction: first hit saturates, a second saturated hit ties.
    load_ray(0, 0, 0, 0, 0, 1, 1);
    pending_tris.push_back(flat_tri(30000 * ONE, 60, 1'b0));
    pending_tris.push_back(flat_tri(20000 * ONE, 61, 1'b1));
    queue_random_rays(200);
    drain();

    // Largest tolerance.
    load_ray(small_coord(), small_coord(), small_coord(), 4 * ONE, -3 * ONE, 2 * ONE, 65535);
    queue_random_rays(250);
    drain();

    // Register extremes.
    load_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
             32'h7FFFFFFF, 0);
    queue_random_rays(200);
    drain();

    // Random small rays; one phase runs with no idling on either side.
    for (int p = 0; p < 4; p++) begin
      load_ray(small_coord(), small_coord(), small_coord(), small_dir(), small_dir(),
               ($urandom_range(1) ? 1 : -1) * $urandom_range(ONE / 4, 4 * ONE),
               ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 16));
      calm = (p == 1);
      queue_random_rays(220);
      drain();
    end
    calm = 1'b0;

    $display("covered %0d triangles over %0d rays, %0d of them hits, under 9 ray settings",
             tri_count, ray_count, hit_count);
    if (expected_hits.size() != 0)
      report_mismatch("results left over", expected_hits.size(), 0);
    if (errors == 0) begin
      $display("tb_ray_triangle_closest_hit: clean");
    end else begin
      $display("tb_ray_triangle_closest_hit: errors");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout after %0d triangles", tri_count);
    $display("tb_ray_triangle_closest_hit: errors");
    $finish;
  end

endmodule
